>>> hw/rtl/sms_pkg.sv
package sms_pkg;

    // Move counter width; the length registers stay 13 bits wide.
    localparam int unsigned COUNT_BITS = 13;
    localparam int unsigned CFG_W      = 13;
    localparam int unsigned LEN_W      = (COUNT_BITS < CFG_W) ? COUNT_BITS : CFG_W;
    localparam int unsigned BTN_W      = 6;
    localparam int unsigned COIL_W     = 4;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_SHORT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MEDIUM = 2'd1;
    localparam logic [IDX_W-1:0] REG_LONG   = 2'd2;

    localparam logic [CFG_W-1:0] SHORT_RST  = 13'd1000;
    localparam logic [CFG_W-1:0] MEDIUM_RST = 13'd2084;
    localparam logic [CFG_W-1:0] LONG_RST   = 13'd4168;

    // Distance codes
    localparam logic [1:0] DIST_SHORT  = 2'd0;
    localparam logic [1:0] DIST_MEDIUM = 2'd1;
    localparam logic [1:0] DIST_LONG   = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] short_steps;
        logic [CFG_W-1:0] medium_steps;
        logic [CFG_W-1:0] long_steps;
    } t_cfg;

    typedef struct packed {
        logic              busy;
        logic [COIL_W-1:0] coils;
    } t_result;

    function automatic logic [COIL_W-1:0] half_step(input logic [2:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

>>> hw/rtl/stepper_move_sequencer.sv
// An accepted input beat's result goes into the output register, or into the skid entry.
// Throughput: one tick per cycle while input ready is high; sequencer state updates per tick.
// A two-entry output stage (result register plus skid) takes one more input beat while
// a result is stalled; input ready drops once both entries hold a result.
// Reset (synchronous, active low) idles the sequencer, turns the coils off, restores
// the default move lengths and empties the output stage.
module stepper_move_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sms_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [sms_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [5:0] buttons
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [3:0] coils, [4] busy_res
);

    sms_pkg::t_cfg    r_cfg;
    sms_pkg::t_result core_res;
    sms_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;
    logic             in_fire, out_fire;

    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = sms_pkg::OUT_TDATA_W'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_steps  <= sms_pkg::SHORT_RST;
            r_cfg.medium_steps <= sms_pkg::MEDIUM_RST;
            r_cfg.long_steps   <= sms_pkg::LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sms_pkg::REG_SHORT:  r_cfg.short_steps  <= i_cfg_wdata;
                sms_pkg::REG_MEDIUM: r_cfg.medium_steps <= i_cfg_wdata;
                sms_pkg::REG_LONG:   r_cfg.long_steps   <= i_cfg_wdata;
                default:             ;
            endcase
        end
    end

    sms_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (in_fire),
        .i_buttons (s_axis_tdata[sms_pkg::BTN_W-1:0]),
        .i_cfg     (r_cfg),
        .o_result  (core_res)
    );

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_out <= r_skid_valid ? r_skid : core_res;
        end else if (in_fire) begin
            if (!r_out_valid) begin
                r_out <= core_res;
            end else begin
                r_skid <= core_res;
            end
        end
    end

endmodule

>>> hw/rtl/sms_core.sv
module sms_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [sms_pkg::BTN_W-1:0]     i_buttons,
    input  sms_pkg::t_cfg                 i_cfg,
    output sms_pkg::t_result              o_result
);

    logic                              r_running, n_running;
    logic                              r_reverse, n_reverse;
    logic [1:0]                        r_dist, n_dist;
    logic [2:0]                        r_phase, n_phase;
    logic [sms_pkg::COUNT_BITS-1:0]    r_done, n_done;
    logic [sms_pkg::COIL_W-1:0]        r_coil, n_coil;

    logic [sms_pkg::BTN_W-1:0]         pressed;
    logic [2:0]                        sel;
    logic                              any_pressed;
    logic [sms_pkg::CFG_W-1:0]         len_reg;
    logic [sms_pkg::COUNT_BITS:0]      next_cnt;
    logic [sms_pkg::COUNT_BITS:0]      len_ext;

    always_comb begin
        pressed     = ~i_buttons;
        any_pressed = |pressed;
        sel         = 3'd0;
        // lowest pressed button wins
        for (int i = sms_pkg::BTN_W - 1; i >= 0; i--) begin
            if (pressed[i]) begin
                sel = 3'(i);
            end
        end
    end

    always_comb begin
        case (r_dist)
            sms_pkg::DIST_SHORT:  len_reg = i_cfg.short_steps;
            sms_pkg::DIST_MEDIUM: len_reg = i_cfg.medium_steps;
            default:              len_reg = i_cfg.long_steps;
        endcase
        len_ext  = (sms_pkg::COUNT_BITS + 1)'(len_reg[sms_pkg::LEN_W-1:0]);
        next_cnt = {1'b0, r_done} + 1'b1;
    end

    always_comb begin
        n_running = r_running;
        n_reverse = r_reverse;
        n_dist    = r_dist;
        n_phase   = r_phase;
        n_done    = r_done;
        n_coil    = r_coil;
        if (!r_running) begin
            if (any_pressed) begin
                n_reverse = (sel >= 3'd3);
                n_dist    = (sel >= 3'd3) ? 2'(sel - 3'd3) : 2'(sel);
                n_running = 1'b1;
                n_phase   = 3'd0;
                n_done    = '0;
            end
        end else begin
            // reverse reads the table backward
            n_coil  = sms_pkg::half_step(r_reverse ? ~r_phase : r_phase);
            n_phase = r_phase + 3'd1;
            if (next_cnt >= len_ext) begin
                n_running = 1'b0;
                n_phase   = 3'd0;
                n_done    = '0;
            end else begin
                n_done = next_cnt[sms_pkg::COUNT_BITS-1:0];
            end
        end
        o_result.coils = n_coil;
        o_result.busy  = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_reverse <= 1'b0;
            r_dist    <= sms_pkg::DIST_SHORT;
            r_phase   <= 3'd0;
            r_done    <= '0;
            r_coil    <= '0;
        end else if (i_tick) begin
            r_running <= n_running;
            r_reverse <= n_reverse;
            r_dist    <= n_dist;
            r_phase   <= n_phase;
            r_done    <= n_done;
            r_coil    <= n_coil;
        end
    end

endmodule

>>> hw/rtl/sms_checker.sv
module sms_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [sms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // input only stalls when a result is pending
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // output stage is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // a pending result is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // coils show off or a half-step pattern: at most two adjacent bits
    a_coil_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[3:0]) <= 2)
            && (m_axis_tdata[3:0] != 4'b0101) && (m_axis_tdata[3:0] != 4'b1010))
        else $error("illegal coil pattern");

endmodule

bind stepper_move_sequencer sms_checker u_sms_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [sms_pkg::IDX_W-1:0] REG_NONE = 2'd3;
    // Half-step coil patterns, entry 0 in the lowest nibble
    localparam logic [31:0] COIL_SEQ = 32'h98C4_6231;
    localparam int DIR_N = 25;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [sms_pkg::BTN_W-1:0]  btn;
        logic                       typed;
        logic [sms_pkg::COIL_W-1:0] coils;
        logic                       busy;
        logic [sms_pkg::IDX_W-1:0]  reg_idx;
        logic [sms_pkg::CFG_W-1:0]  value;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sms_pkg::IDX_W-1:0]       i_cfg_index;
    logic [sms_pkg::CFG_W-1:0]       i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [sms_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [5:0] buttons
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [sms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [3:0] coils, [4] busy_res

    // Sequencer model state and move lengths
    logic                       seq_running;
    logic                       seq_reverse;
    logic [1:0]                 seq_dist;
    logic [2:0]                 seq_phase;
    logic [sms_pkg::LEN_W-1:0]  seq_steps;
    logic [sms_pkg::COIL_W-1:0] seq_coils;
    logic [sms_pkg::CFG_W-1:0]  len_short;
    logic [sms_pkg::CFG_W-1:0]  len_medium;
    logic [sms_pkg::CFG_W-1:0]  len_long;

    sms_pkg::t_result coil_result_q[$];
    sms_pkg::t_result want;
    t_row             dir_rows [DIR_N];
    int               mismatch_cnt;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_req;
    int               hold_left;

    stepper_move_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic advance_sequencer(input logic [sms_pkg::BTN_W-1:0] btn,
                                     output sms_pkg::t_result res);
        logic [sms_pkg::BTN_W-1:0] pressed;
        int                        sel;
        logic [2:0]                idx;
        logic [sms_pkg::LEN_W:0]   next_cnt;
        logic [sms_pkg::LEN_W-1:0] len;
        pressed = ~btn;
        if (!seq_running) begin
            if (pressed != '0) begin
                sel = 0;
                while (!pressed[sel]) sel++;
                seq_reverse = (sel >= 3);
                seq_dist    = (sel >= 3) ? 2'(sel - 3) : 2'(sel);
                seq_running = 1'b1;
                seq_phase   = 3'd0;
                seq_steps   = '0;
            end
        end else begin
            idx       = seq_reverse ? 3'd7 - seq_phase : seq_phase;
            seq_coils = COIL_SEQ[idx*4 +: 4];
            seq_phase = seq_phase + 3'd1;
            next_cnt  = {1'b0, seq_steps} + 1'b1;
            case (seq_dist)
                sms_pkg::DIST_SHORT:  len = len_short[sms_pkg::LEN_W-1:0];
                sms_pkg::DIST_MEDIUM: len = len_medium[sms_pkg::LEN_W-1:0];
                default:              len = len_long[sms_pkg::LEN_W-1:0];
            endcase
            // a zero length still ends after the first driven step
            if (next_cnt >= {1'b0, len}) begin
                seq_running = 1'b0;
                seq_phase   = 3'd0;
                seq_steps   = '0;
            end else begin
                seq_steps = next_cnt[sms_pkg::LEN_W-1:0];
            end
        end
        res.coils = seq_coils;
        res.busy  = seq_running;
    endtask

    function automatic logic [sms_pkg::BTN_W-1:0] rand_buttons();
        int                        r;
        int                        k;
        logic [sms_pkg::BTN_W-1:0] b;
        r = $urandom_range(99);
        b = sms_pkg::BTN_W'($urandom);
        if (r < 20) begin
            b = '1;
        end else if (r < 80) begin
            // press button k, release every lower one, leave higher ones random
            k = $urandom_range(sms_pkg::BTN_W - 1);
            b = b | sms_pkg::BTN_W'((1 << k) - 1);
            b[k] = 1'b0;
        end
        return b;
    endfunction

    task automatic push_tick(input logic [sms_pkg::BTN_W-1:0] btn, input logic typed,
                             input sms_pkg::t_result typed_res);
        sms_pkg::t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sms_pkg::IN_TDATA_W - sms_pkg::BTN_W){1'b0}}, btn};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_sequencer(btn, res);
        coil_result_q.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (coil_result_q.size() != 0) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it
    task automatic write_reg(input logic [sms_pkg::IDX_W-1:0] idx,
                             input logic [sms_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            sms_pkg::REG_SHORT:  len_short  = val;
            sms_pkg::REG_MEDIUM: len_medium = val;
            sms_pkg::REG_LONG:   len_long   = val;
            default:             ;
        endcase
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (coil_result_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: tdata %h", m_axis_tdata);
            end else begin
                want = coil_result_q.pop_front();
                if (m_axis_tdata[3:0] !== want.coils || m_axis_tdata[4] !== want.busy ||
                    m_axis_tdata[sms_pkg::OUT_TDATA_W-1:5] !== '0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: coils exp %h got %h, busy exp %b got %b, pad %h",
                                 want.coils, m_axis_tdata[3:0], want.busy, m_axis_tdata[4],
                                 m_axis_tdata[sms_pkg::OUT_TDATA_W-1:5]);
                end
            end
        end
    end

    initial begin
        int                        ph;
        int                        n;
        int                        quota;
        logic [sms_pkg::CFG_W-1:0] l0;
        logic [sms_pkg::CFG_W-1:0] l1;
        logic [sms_pkg::CFG_W-1:0] l2;
        sms_pkg::t_result          typed_res;

        seq_running    = 1'b0;
        seq_reverse    = 1'b0;
        seq_dist       = sms_pkg::DIST_SHORT;
        seq_phase      = 3'd0;
        seq_steps      = '0;
        seq_coils      = '0;
        len_short      = sms_pkg::SHORT_RST;
        len_medium     = sms_pkg::MEDIUM_RST;
        len_long       = sms_pkg::LONG_RST;
        mismatch_cnt   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        hold_left      = 0;

        // kind, buttons, typed, coils, busy, register, value
        dir_rows = '{
            '{ROW_TICK, 6'h3F, 1'b1, 4'h0, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b1, 4'h0, 1'b0, REG_NONE,            13'd0},
            '{ROW_CFG,  6'h3F, 1'b0, 4'h0, 1'b0, sms_pkg::REG_SHORT,  13'd1},
            '{ROW_CFG,  6'h3F, 1'b0, 4'h0, 1'b0, sms_pkg::REG_MEDIUM, 13'd2},
            '{ROW_CFG,  6'h3F, 1'b0, 4'h0, 1'b0, sms_pkg::REG_LONG,   13'd0},
            '{ROW_CFG,  6'h3F, 1'b0, 4'h0, 1'b0, REG_NONE,            13'd8191},
            '{ROW_TICK, 6'h3E, 1'b1, 4'h0, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h00, 1'b1, 4'h1, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h00, 1'b1, 4'h1, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b0, 4'h0, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b1, 4'h1, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3D, 1'b1, 4'h1, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h2A, 1'b0, 4'h0, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h15, 1'b1, 4'h3, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3B, 1'b1, 4'h3, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h00, 1'b1, 4'h1, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h37, 1'b1, 4'h1, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b1, 4'h9, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h2F, 1'b1, 4'h9, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b0, 4'h0, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b1, 4'h8, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h1F, 1'b1, 4'h8, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b1, 4'h9, 1'b0, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h07, 1'b1, 4'h9, 1'b1, REG_NONE,            13'd0},
            '{ROW_TICK, 6'h3F, 1'b1, 4'h9, 1'b0, REG_NONE,            13'd0}
        };

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                i_cfg_we <= 1'b0;
                typed_res.coils = dir_rows[i].coils;
                typed_res.busy  = dir_rows[i].busy;
                push_tick(dir_rows[i].btn, dir_rows[i].typed, typed_res);
            end
        end

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    l0 = 13'd3; l1 = 13'd5; l2 = 13'd8;
                    send_idle_pct = 0; recv_stall_pct = 0; quota = 120;
                end
                1: begin
                    l0 = 13'd1; l1 = 13'd2; l2 = 13'd7;
                    send_idle_pct = 65; recv_stall_pct = 0; quota = 120;
                end
                2: begin
                    l0 = 13'd0; l1 = 13'd13; l2 = 13'd31;
                    send_idle_pct = 0; recv_stall_pct = 65; quota = 120;
                end
                3: begin
                    // longer moves: hold the quota down, a move runs past it
                    l0 = 13'd24; l1 = 13'd36; l2 = 13'd48;
                    send_idle_pct = 21; recv_stall_pct = 21; quota = 10;
                end
                4: begin
                    l0 = 13'd2; l1 = 13'd1; l2 = 13'd4;
                    send_idle_pct = 21; recv_stall_pct = 21; quota = 120;
                end
                default: begin
                    l0 = 13'd9; l1 = 13'd17; l2 = 13'd2;
                    send_idle_pct = 0; recv_stall_pct = 0; quota = 60;
                end
            endcase
            drain_results();
            write_reg(sms_pkg::REG_SHORT, l0);
            write_reg(sms_pkg::REG_MEDIUM, l1);
            write_reg(sms_pkg::REG_LONG, l2);
            write_reg(REG_NONE, sms_pkg::CFG_W'($urandom));
            i_cfg_we <= 1'b0;
            n = 0;
            // finish any move in progress before the next register set
            while (n < quota || seq_running) begin
                if (ph == 0 && n == 60)
                    hold_req = 80;
                if (ph == 1 && n == 60)
                    drain_results();
                push_tick(rand_buttons(), 1'b0, typed_res);
                n++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && coil_result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
